// ----- rtl/tlik_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlik_pkg: shared constants and helpers for the two-link arm IK core
// Fixed-point widths, CORDIC arctangent table and angle helpers.
// ----------------------------------------------------------------------------
package tlik_pkg;

  localparam int CORDIC_STAGES  = 16;
  localparam int DIST_FRAC_BITS = 4;
  localparam int ANG_FRAC       = 16;
  localparam int PRE_SHIFT      = 24;
  localparam int ATAN_LEN       = 24;

  localparam int CORDIC_N  = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
  localparam int LEN_W     = 10 + DIST_FRAC_BITS;
  localparam int SUM_W     = (LEN_W + 2 > 16) ? LEN_W + 2 : 16;
  localparam int ISQ_W     = 2 * SUM_W;
  localparam int ISQ_STEPS = SUM_W;
  localparam int CIN_W     = SUM_W + 1;
  localparam int CX_W      = CIN_W + PRE_SHIFT + 3;
  localparam int Z_W       = 25;
  localparam int TOT_W     = 28;

  localparam logic signed [TOT_W-1:0] DEG90 = TOT_W'(90) <<< ANG_FRAC;

  localparam logic [2:0] REG_FIRST_LINK  = 3'd0;
  localparam logic [2:0] REG_SECOND_LINK = 3'd1;
  localparam logic [2:0] REG_MOUNT       = 3'd2;
  localparam logic [2:0] REG_GRIPPER     = 3'd3;
  localparam logic [2:0] REG_OFFSET1     = 3'd4;
  localparam logic [2:0] REG_OFFSET2     = 3'd5;

  // arctangent of 2^-i in units of 2^-16 degree
  function automatic logic signed [Z_W-1:0] atan_entry(input int i);
    logic signed [Z_W-1:0] v;
    unique case (i)
      0: v = Z_W'(2949120);
      1: v = Z_W'(1740967);
      2: v = Z_W'(919879);
      3: v = Z_W'(466945);
      4: v = Z_W'(234379);
      5: v = Z_W'(117304);
      6: v = Z_W'(58666);
      7: v = Z_W'(29335);
      8: v = Z_W'(14668);
      9: v = Z_W'(7334);
      10: v = Z_W'(3667);
      11: v = Z_W'(1833);
      12: v = Z_W'(917);
      13: v = Z_W'(458);
      14: v = Z_W'(229);
      15: v = Z_W'(115);
      16: v = Z_W'(57);
      17: v = Z_W'(29);
      18: v = Z_W'(14);
      19: v = Z_W'(7);
      20: v = Z_W'(4);
      21: v = Z_W'(2);
      22: v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // drop the fraction, rounding toward zero
  function automatic logic signed [TOT_W-1:0] deg_trunc(input logic signed [TOT_W-1:0] v);
    logic signed [TOT_W-1:0] r;
    if (v >= 0) begin
      r = v >>> ANG_FRAC;
    end else begin
      r = -((-v) >>> ANG_FRAC);
    end
    return r;
  endfunction

  function automatic logic signed [9:0] sat10(input logic signed [TOT_W-1:0] v);
    logic signed [9:0] r;
    if (v > TOT_W'(511)) begin
      r = 10'sd511;
    end else if (v < -TOT_W'(512)) begin
      r = -10'sd512;
    end else begin
      r = v[9:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/tlik_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlik_isqrt: pipelined integer square root
// One result bit per stage, restoring digit-by-digit method, floor result.
// ----------------------------------------------------------------------------
module tlik_isqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [tlik_pkg::ISQ_W-1:0]  radicand,
  output logic [tlik_pkg::SUM_W-1:0]  root
);

  logic [tlik_pkg::ISQ_W-1:0] rem_q [0:tlik_pkg::ISQ_STEPS-1];
  logic [tlik_pkg::ISQ_W-1:0] res_q [0:tlik_pkg::ISQ_STEPS-1];

  for (genvar k = 0; k < tlik_pkg::ISQ_STEPS; k++) begin : g_step
    localparam logic [tlik_pkg::ISQ_W-1:0] BITV =
      tlik_pkg::ISQ_W'(1) << (tlik_pkg::ISQ_W - 2 - 2 * k);
    logic [tlik_pkg::ISQ_W-1:0] rem_in;
    logic [tlik_pkg::ISQ_W-1:0] res_in;
    logic [tlik_pkg::ISQ_W-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_in = radicand;
      assign res_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
    end

    assign trial = res_in + BITV;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_q[k] <= rem_in - trial;
          res_q[k] <= (res_in >> 1) + BITV;
        end else begin
          rem_q[k] <= rem_in;
          res_q[k] <= res_in >> 1;
        end
      end
    end
  end

  assign root = res_q[tlik_pkg::ISQ_STEPS-1][tlik_pkg::SUM_W-1:0];

endmodule

// ----- rtl/tlik_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlik_cordic: pipelined CORDIC arctangent (vectoring mode)
// Returns atan2(vy, vx) for vx >= 0 in units of 2^-16 degree.
// ----------------------------------------------------------------------------
module tlik_cordic (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [tlik_pkg::CIN_W-1:0]  vx,
  input  logic signed [tlik_pkg::CIN_W-1:0]  vy,
  output logic signed [tlik_pkg::Z_W-1:0]    angle
);

  logic signed [tlik_pkg::CX_W-1:0] xs [0:tlik_pkg::CORDIC_N];
  logic signed [tlik_pkg::CX_W-1:0] ys [0:tlik_pkg::CORDIC_N];
  logic signed [tlik_pkg::Z_W-1:0]  zs [0:tlik_pkg::CORDIC_N];

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= tlik_pkg::CX_W'(vx) <<< tlik_pkg::PRE_SHIFT;
      ys[0] <= tlik_pkg::CX_W'(vy) <<< tlik_pkg::PRE_SHIFT;
      zs[0] <= '0;
    end
  end

  for (genvar i = 1; i <= tlik_pkg::CORDIC_N; i++) begin : g_stage
    localparam logic signed [tlik_pkg::Z_W-1:0] ATAN = tlik_pkg::atan_entry(i - 1);
    logic signed [tlik_pkg::CX_W-1:0] dx;
    logic signed [tlik_pkg::CX_W-1:0] dy;

    assign dx = ys[i-1] >>> (i - 1);
    assign dy = xs[i-1] >>> (i - 1);

    always_ff @(posedge clk) begin
      if (en) begin
        if (ys[i-1] > 0) begin
          xs[i] <= xs[i-1] + dx;
          ys[i] <= ys[i-1] - dy;
          zs[i] <= zs[i-1] + ATAN;
        end else begin
          xs[i] <= xs[i-1] - dx;
          ys[i] <= ys[i-1] + dy;
          zs[i] <= zs[i-1] - ATAN;
        end
      end
    end
  end

  assign angle = zs[tlik_pkg::CORDIC_N];

endmodule

// ----- rtl/two_link_arm_ik_top_approach_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_link_arm_ik_top_approach_core: top-approach IK for a two-link arm
// Horizontal target distance in, both joint angles and a reach flag out.
// ----------------------------------------------------------------------------
// Channel  | Handshake           | Payload
// target   | in_valid/in_ready   | target_distance
// result   | out_valid/out_ready | first_joint_angle, second_joint_angle, unreachable
// config   | cfg_wen             | cfg_index, cfg_data
//
// One transaction per cycle sustained while out_ready holds; the depth is set by two
// square-root pipelines (one bit per stage) and the CORDIC pipeline (one
// iteration per stage).
// Reset restores the register defaults and empties the pipeline.
// A stalled result sits in the output register; a skid register takes one more,
// and only then does in_ready drop and the whole pipeline hold.
// ----------------------------------------------------------------------------
module two_link_arm_ik_top_approach_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [2:0]        cfg_index,
  input  logic [9:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [14:0] target_distance,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [9:0] first_joint_angle,
  output logic signed [9:0] second_joint_angle,
  output logic              unreachable
);

  localparam int LW  = tlik_pkg::LEN_W;
  localparam int SW  = tlik_pkg::SUM_W;
  localparam int QW  = tlik_pkg::ISQ_W;
  localparam int QS  = tlik_pkg::ISQ_STEPS;
  localparam int CW  = tlik_pkg::CIN_W;
  localparam int ZW  = tlik_pkg::Z_W;
  localparam int TW  = tlik_pkg::TOT_W;
  localparam int CL  = tlik_pkg::CORDIC_N + 1;
  localparam int TOT = 7 + 2 * QS + tlik_pkg::CORDIC_N;

  typedef struct packed {
    logic [LW-1:0]        a;
    logic [LW-1:0]        b;
    logic signed [LW:0]   h;
    logic signed [14:0]   x;
    logic                 ok;
  } side1_t;

  typedef struct packed {
    logic signed [LW:0]   h;
    logic signed [14:0]   x;
    logic                 ok;
  } side2_t;

  typedef struct packed {
    logic                 xle0;
    logic                 ok;
  } side3_t;

  // configuration
  logic [9:0]        first_len;
  logic [9:0]        second_len;
  logic [9:0]        mount_h;
  logic [9:0]        grip_len;
  logic signed [8:0] offset1;
  logic signed [8:0] offset2;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_len  <= 10'd150;
      second_len <= 10'd150;
      mount_h    <= 10'd200;
      grip_len   <= 10'd50;
      offset1    <= '0;
      offset2    <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        tlik_pkg::REG_FIRST_LINK:  first_len  <= cfg_data;
        tlik_pkg::REG_SECOND_LINK: second_len <= cfg_data;
        tlik_pkg::REG_MOUNT:       mount_h    <= cfg_data;
        tlik_pkg::REG_GRIPPER:     grip_len   <= cfg_data;
        tlik_pkg::REG_OFFSET1:     offset1    <= cfg_data[8:0];
        tlik_pkg::REG_OFFSET2:     offset2    <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // flow control
  logic           en;
  logic           skid_valid;
  logic [TOT-1:0] vpipe;
  logic           push;

  assign en       = !skid_valid;
  assign in_ready = en;
  assign push     = en && vpipe[TOT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[TOT-2:0], in_valid};
    end
  end

  // stage 1: scale lengths, form h
  logic signed [10:0] h_mm;
  logic signed [LW:0]  s1_h;
  logic signed [14:0]  s1_x;
  logic [LW-1:0]       s1_a;
  logic [LW-1:0]       s1_b;

  assign h_mm = $signed({1'b0, mount_h}) - $signed({1'b0, grip_len});

  always_ff @(posedge clk) begin
    if (en) begin
      s1_h <= (LW+1)'(h_mm) <<< tlik_pkg::DIST_FRAC_BITS;
      s1_x <= target_distance;
      s1_a <= LW'(first_len) << tlik_pkg::DIST_FRAC_BITS;
      s1_b <= LW'(second_len) << tlik_pkg::DIST_FRAC_BITS;
    end
  end

  // stage 2: squares
  logic signed [2*LW+1:0] hh_full;
  logic signed [29:0]     xx_full;
  logic [LW:0]            ab_sum;
  logic signed [LW:0]     ab_diff;
  logic [2*LW+1:0]        far_full;
  logic signed [2*LW+1:0] near_full;
  logic [QW-1:0]          s2_hh;
  logic [QW-1:0]          s2_xx;
  logic [QW-1:0]          s2_far;
  logic [QW-1:0]          s2_near;
  logic signed [LW:0]     s2_h;
  logic signed [14:0]     s2_x;
  logic [LW-1:0]          s2_a;
  logic [LW-1:0]          s2_b;

  assign hh_full   = s1_h * s1_h;
  assign xx_full   = s1_x * s1_x;
  assign ab_sum    = (LW+1)'(s1_a) + (LW+1)'(s1_b);
  assign ab_diff   = $signed({1'b0, s1_a}) - $signed({1'b0, s1_b});
  assign far_full  = ab_sum * ab_sum;
  assign near_full = ab_diff * ab_diff;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_hh   <= QW'($unsigned(hh_full));
      s2_xx   <= QW'($unsigned(xx_full));
      s2_far  <= QW'(far_full);
      s2_near <= QW'($unsigned(near_full));
      s2_h    <= s1_h;
      s2_x    <= s1_x;
      s2_a    <= s1_a;
      s2_b    <= s1_b;
    end
  end

  // stage 3: reach test
  logic [QW-1:0] c2_sum;
  logic [QW-1:0] s3_c2;
  side1_t        s3_side;

  assign c2_sum = s2_hh + s2_xx;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_c2      <= c2_sum;
      s3_side.a  <= s2_a;
      s3_side.b  <= s2_b;
      s3_side.h  <= s2_h;
      s3_side.x  <= s2_x;
      s3_side.ok <= (s2_h > 0) && (c2_sum <= s2_far) && (c2_sum >= s2_near);
    end
  end

  // c = floor(sqrt(h^2 + x^2))
  logic [SW-1:0] root_c;
  side1_t        side1_q [0:QS-1];

  tlik_isqrt u_isqrt_c (
    .clk      (clk),
    .en       (en),
    .radicand (s3_c2),
    .root     (root_c)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side1_q[0] <= s3_side;
      for (int k = 1; k < QS; k++) begin
        side1_q[k] <= side1_q[k-1];
      end
    end
  end

  // stage 4: half-angle factors
  logic [SW-1:0] ea;
  logic [SW-1:0] eb;
  logic [SW-1:0] s4_sum;
  logic [SW-1:0] s4_p1;
  logic [SW-1:0] s4_p2;
  logic [SW-1:0] s4_p3;
  side2_t        s4_side;

  assign ea = SW'(side1_q[QS-1].a);
  assign eb = SW'(side1_q[QS-1].b);

  always_ff @(posedge clk) begin
    if (en) begin
      s4_sum     <= ea + eb + root_c;
      s4_p1      <= eb + root_c - ea;
      s4_p2      <= ea + eb - root_c;
      s4_p3      <= ea + root_c - eb;
      s4_side.h  <= side1_q[QS-1].h;
      s4_side.x  <= side1_q[QS-1].x;
      s4_side.ok <= side1_q[QS-1].ok;
    end
  end

  // stage 5: products under the square roots
  logic [QW-1:0] s5_ub;
  logic [QW-1:0] s5_vb;
  logic [QW-1:0] s5_uc;
  logic [QW-1:0] s5_vc;
  side2_t        s5_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_ub   <= QW'(s4_p1) * QW'(s4_p2);
      s5_vb   <= QW'(s4_p3) * QW'(s4_sum);
      s5_uc   <= QW'(s4_p1) * QW'(s4_p3);
      s5_vc   <= QW'(s4_p2) * QW'(s4_sum);
      s5_side <= s4_side;
    end
  end

  logic [SW-1:0] su_b;
  logic [SW-1:0] sv_b;
  logic [SW-1:0] su_c;
  logic [SW-1:0] sv_c;
  side2_t        side2_q [0:QS-1];

  tlik_isqrt u_isqrt_ub (.clk(clk), .en(en), .radicand(s5_ub), .root(su_b));
  tlik_isqrt u_isqrt_vb (.clk(clk), .en(en), .radicand(s5_vb), .root(sv_b));
  tlik_isqrt u_isqrt_uc (.clk(clk), .en(en), .radicand(s5_uc), .root(su_c));
  tlik_isqrt u_isqrt_vc (.clk(clk), .en(en), .radicand(s5_vc), .root(sv_c));

  always_ff @(posedge clk) begin
    if (en) begin
      side2_q[0] <= s5_side;
      for (int k = 1; k < QS; k++) begin
        side2_q[k] <= side2_q[k-1];
      end
    end
  end

  // arctangents
  logic                 xle0;
  logic signed [CW-1:0] arm_vx;
  logic signed [CW-1:0] arm_vy;
  logic signed [ZW-1:0] z_b;
  logic signed [ZW-1:0] z_c;
  logic signed [ZW-1:0] z_arm;
  side3_t               side3_q [0:CL-1];

  assign xle0   = side2_q[QS-1].x <= 0;
  assign arm_vx = xle0 ? CW'(side2_q[QS-1].h) : CW'(side2_q[QS-1].x);
  assign arm_vy = xle0 ? CW'(side2_q[QS-1].x) : CW'(side2_q[QS-1].h);

  tlik_cordic u_cordic_b (
    .clk   (clk),
    .en    (en),
    .vx    ($signed(CW'(sv_b))),
    .vy    ($signed(CW'(su_b))),
    .angle (z_b)
  );

  tlik_cordic u_cordic_c (
    .clk   (clk),
    .en    (en),
    .vx    ($signed(CW'(sv_c))),
    .vy    ($signed(CW'(su_c))),
    .angle (z_c)
  );

  tlik_cordic u_cordic_arm (
    .clk   (clk),
    .en    (en),
    .vx    (arm_vx),
    .vy    (arm_vy),
    .angle (z_arm)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side3_q[0].xle0 <= xle0;
      side3_q[0].ok   <= side2_q[QS-1].ok;
      for (int k = 1; k < CL; k++) begin
        side3_q[k] <= side3_q[k-1];
      end
    end
  end

  // stage 6: combine angles
  logic signed [TW-1:0] ang_b;
  logic signed [TW-1:0] ang_c;
  logic signed [TW-1:0] total;
  logic signed [TW-1:0] s6_total;
  logic signed [TW-1:0] s6_arm2;
  logic                 s6_ok;

  assign ang_b = tlik_pkg::deg_trunc(TW'(z_b) <<< 1);
  assign ang_c = tlik_pkg::deg_trunc(TW'(z_c) <<< 1);
  assign total = (side3_q[CL-1].xle0 ? tlik_pkg::DEG90 : TW'(0)) + TW'(z_arm)
               + ((ang_b + TW'(offset1)) <<< tlik_pkg::ANG_FRAC);

  always_ff @(posedge clk) begin
    if (en) begin
      s6_total <= total;
      s6_arm2  <= ang_c + TW'(offset2);
      s6_ok    <= side3_q[CL-1].ok;
    end
  end

  logic signed [9:0] arm1_res;
  logic signed [9:0] arm2_res;

  assign arm1_res = s6_ok ? tlik_pkg::sat10(tlik_pkg::deg_trunc(s6_total)) : 10'sd0;
  assign arm2_res = s6_ok ? tlik_pkg::sat10(s6_arm2) : 10'sd0;

  // output register and skid
  logic signed [9:0] skid_arm1;
  logic signed [9:0] skid_arm2;
  logic              skid_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        first_joint_angle  <= skid_arm1;
        second_joint_angle <= skid_arm2;
        unreachable        <= skid_bad;
      end else begin
        first_joint_angle  <= arm1_res;
        second_joint_angle <= arm2_res;
        unreachable        <= !s6_ok;
      end
    end else if (push) begin
      skid_arm1 <= arm1_res;
      skid_arm2 <= arm2_res;
      skid_bad  <= !s6_ok;
    end
  end

endmodule

// ----- rtl/tlik_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlik_checker: port-level checks for the two-link arm IK core
// Watches the result channel and the back-pressure it causes.
// ----------------------------------------------------------------------------
module tlik_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [9:0] first_joint_angle,
  input logic signed [9:0] second_joint_angle,
  input logic              unreachable
);

  // a stalled result transaction must persist
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && unreachable |-> first_joint_angle == 10'sd0 && second_joint_angle == 10'sd0)
    else $error("unreachable result carries non-zero angles");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // input back-pressure only when a result is waiting
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

endmodule

bind two_link_arm_ik_top_approach_core tlik_checker u_tlik_checker (
  .clk                (clk),
  .rst                (rst),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .first_joint_angle  (first_joint_angle),
  .second_joint_angle (second_joint_angle),
  .unreachable        (unreachable)
);
